>>> src/iptrt_pkg.sv
// Shared constants and types for the I/O port trap range table.
package iptrt_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int ADDR_WIDTH = 16;
    localparam int LEN_WIDTH  = ADDR_WIDTH + 1;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int REF_W      = 8;
    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    typedef enum logic [1:0] {
        FN_REGISTER   = 2'd0,
        FN_DEREGISTER = 2'd1,
        FN_GET        = 2'd2,
        FN_PUT        = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_OVERLAP  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_DEFERRED = 3'd4,
        ST_BADREL   = 3'd5,
        ST_BUSY     = 3'd6
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // input transfer: latch the request
        logic commit;   // update the table and load the result register
    } dp_cmd_t;

endpackage

>>> src/io_port_trap_range_table.sv
// Top level of the I/O port trap range table: controller plus datapath.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    func, port_address, span_length, handler_tag,
//                                     context_tag, slot_index
//  m_       out  m_valid / m_ready    status, hit_slot, hit_handler, hit_context,
//                                     entry_freed
//
// Each request has a capture step, then a commit step in which all NUM_SLOTS
// entries are compared in parallel and the table is written back. A new request
// is accepted only after the previous one has committed.
// A new request is accepted while a result waits; its commit stalls until the
// result register is free. Synchronous active-low reset clears all valid bits.
module io_port_trap_range_table
    import iptrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [ADDR_WIDTH-1:0] s_port_address,
    input  logic [LEN_WIDTH-1:0]  s_span_length,
    input  logic [7:0]            s_handler_tag,
    input  logic [7:0]            s_context_tag,
    input  logic [3:0]            s_slot_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [3:0]            m_hit_slot,
    output logic [7:0]            m_hit_handler,
    output logic [7:0]            m_hit_context,
    output logic                  m_entry_freed
);

    dp_cmd_t cmd;

    iptrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    iptrt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_port_address (s_port_address),
        .s_span_length  (s_span_length),
        .s_handler_tag  (s_handler_tag),
        .s_context_tag  (s_context_tag),
        .s_slot_index   (s_slot_index),
        .m_status       (m_status),
        .m_hit_slot     (m_hit_slot),
        .m_hit_handler  (m_hit_handler),
        .m_hit_context  (m_hit_context),
        .m_entry_freed  (m_entry_freed)
    );

endmodule

>>> src/iptrt_ctrl.sv
// Sequencer for the range table: request capture, commit and result handshake.
module iptrt_ctrl
    import iptrt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   commit;

    assign s_ready = (state_reg == IDLE);
    assign accept  = s_valid && s_ready;
    // the result register must be free, or freed by this transfer
    assign commit  = (state_reg == EXEC) && (!m_valid_reg || m_ready);

    assign cmd.capture = accept;
    assign cmd.commit  = commit;
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    state_next = EXEC;
                end
            end
            EXEC: begin
                if (commit) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase

        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("commit did not present a result");

    a_stall_holds_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EXEC) && m_valid_reg && !m_ready |=> (state_reg == EXEC))
        else $error("request left EXEC while result register was occupied");

    a_no_accept_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !accept)
        else $error("second request accepted before commit");

endmodule

>>> src/iptrt_dp.sv
// Range table storage, parallel range compare, write-back and result register.
module iptrt_dp
    import iptrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    input  logic [1:0]            s_func,
    input  logic [ADDR_WIDTH-1:0] s_port_address,
    input  logic [LEN_WIDTH-1:0]  s_span_length,
    input  logic [7:0]            s_handler_tag,
    input  logic [7:0]            s_context_tag,
    input  logic [3:0]            s_slot_index,
    output logic [2:0]            m_status,
    output logic [3:0]            m_hit_slot,
    output logic [7:0]            m_hit_handler,
    output logic [7:0]            m_hit_context,
    output logic                  m_entry_freed
);

    // captured request
    func_t                 func_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [LEN_WIDTH-1:0]  len_reg;
    logic [7:0]            htag_reg;
    logic [7:0]            ctag_reg;
    logic [3:0]            sidx_reg;

    // table
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [ADDR_WIDTH-1:0] start_reg [NUM_SLOTS];
    logic [LEN_WIDTH-1:0]  end_reg   [NUM_SLOTS];
    logic [REF_W-1:0]      ref_reg   [NUM_SLOTS];
    logic                  pend_reg  [NUM_SLOTS];
    logic [7:0]            hand_reg  [NUM_SLOTS];
    logic [7:0]            ctx_reg   [NUM_SLOTS];

    // result register
    status_t     status_reg, status_next;
    logic [3:0]  slot_out_reg, slot_out_next;
    logic [7:0]  hand_out_reg, hand_out_next;
    logic [7:0]  ctx_out_reg, ctx_out_next;
    logic        freed_reg, freed_next;

    logic [LEN_WIDTH-1:0] end_w;
    logic [LEN_WIDTH-1:0] addr_ext;
    logic [NUM_SLOTS-1:0] free_vec, clash_vec, point_vec;
    logic                 free_any, clash_any, point_any;
    logic [SLOT_W-1:0]    free_idx, clash_idx, point_idx;
    logic [SLOT_W-1:0]    sidx_slot, wr_idx;
    logic                 sidx_ok;
    logic [REF_W-1:0]     ref_sel;
    logic                 pend_sel;
    logic                 valid_sel;

    // write-back controls
    logic do_load, do_free, do_pend, do_inc, do_dec;

    function automatic logic [SLOT_W:0] first_set(input logic [NUM_SLOTS-1:0] v);
        logic [SLOT_W:0] r;
        r = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, SLOT_W'(i)};
            end
        end
        return r;
    endfunction

    assign addr_ext = {1'b0, addr_reg};
    assign end_w    = addr_ext + len_reg;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            free_vec[i]  = !valid_reg[i];
            clash_vec[i] = valid_reg[i] &&
                           !((end_w <= {1'b0, start_reg[i]}) || (end_reg[i] <= addr_ext));
            point_vec[i] = valid_reg[i] && (start_reg[i] <= addr_reg) &&
                           (addr_ext < end_reg[i]);
        end
    end

    assign {free_any, free_idx}   = first_set(free_vec);
    assign {clash_any, clash_idx} = first_set(clash_vec);
    assign {point_any, point_idx} = first_set(point_vec);

    assign sidx_slot = SLOT_W'(sidx_reg);
    assign sidx_ok   = (32'(sidx_reg) < NUM_SLOTS);

    always_comb begin
        case (func_reg)
            FN_REGISTER: wr_idx = free_idx;
            FN_PUT:      wr_idx = sidx_slot;
            default:     wr_idx = point_idx;
        endcase
    end

    assign ref_sel   = ref_reg[wr_idx];
    assign pend_sel  = pend_reg[wr_idx];
    assign valid_sel = valid_reg[wr_idx];

    always_comb begin
        do_load       = 1'b0;
        do_free       = 1'b0;
        do_pend       = 1'b0;
        do_inc        = 1'b0;
        do_dec        = 1'b0;
        status_next   = ST_DONE;
        slot_out_next = '0;
        hand_out_next = '0;
        ctx_out_next  = '0;
        freed_next    = 1'b0;
        case (func_reg)
            FN_REGISTER: begin
                if (!free_any) begin
                    status_next = ST_FULL;
                end else if (clash_any) begin
                    status_next   = ST_OVERLAP;
                    slot_out_next = 4'(clash_idx);
                end else begin
                    do_load       = 1'b1;
                    slot_out_next = 4'(free_idx);
                end
            end
            FN_DEREGISTER: begin
                if (!point_any) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    slot_out_next = 4'(point_idx);
                    if (ref_sel == '0) begin
                        do_free    = 1'b1;
                        freed_next = 1'b1;
                    end else begin
                        do_pend     = 1'b1;
                        status_next = ST_DEFERRED;
                    end
                end
            end
            FN_GET: begin
                // whole access must fit inside the entry
                if (!point_any || (len_reg == '0) || (end_reg[wr_idx] < end_w)) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    slot_out_next = 4'(point_idx);
                    if (ref_sel == REF_MAX) begin
                        status_next = ST_BUSY;
                    end else begin
                        do_inc        = 1'b1;
                        hand_out_next = hand_reg[wr_idx];
                        ctx_out_next  = ctx_reg[wr_idx];
                    end
                end
            end
            default: begin
                slot_out_next = sidx_reg;
                if (!sidx_ok || !valid_sel || (ref_sel == '0)) begin
                    status_next = ST_BADREL;
                end else begin
                    do_dec = 1'b1;
                    if (pend_sel && (ref_sel == REF_W'(1))) begin
                        do_free    = 1'b1;
                        freed_next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func_t'(s_func);
            addr_reg <= s_port_address;
            len_reg  <= s_span_length;
            htag_reg <= s_handler_tag;
            ctag_reg <= s_context_tag;
            sidx_reg <= s_slot_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit) begin
            if (do_load) begin
                valid_reg[wr_idx] <= 1'b1;
            end else if (do_free) begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (do_load) begin
                start_reg[wr_idx] <= addr_reg;
                end_reg[wr_idx]   <= end_w;
                ref_reg[wr_idx]   <= '0;
                pend_reg[wr_idx]  <= 1'b0;
                hand_reg[wr_idx]  <= htag_reg;
                ctx_reg[wr_idx]   <= ctag_reg;
            end
            if (do_free) begin
                ref_reg[wr_idx]  <= '0;
                pend_reg[wr_idx] <= 1'b0;
            end else if (do_dec) begin
                ref_reg[wr_idx] <= ref_sel - REF_W'(1);
            end else if (do_inc) begin
                ref_reg[wr_idx] <= ref_sel + REF_W'(1);
            end
            if (do_pend) begin
                pend_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg   <= status_next;
            slot_out_reg <= slot_out_next;
            hand_out_reg <= hand_out_next;
            ctx_out_reg  <= ctx_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freed_reg <= 1'b0;
        end else if (cmd.commit) begin
            freed_reg <= freed_next;
        end
    end

    assign m_status      = status_reg;
    assign m_hit_slot    = slot_out_reg;
    assign m_hit_handler = hand_out_reg;
    assign m_hit_context = ctx_out_reg;
    assign m_entry_freed = freed_reg;

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && do_load |=> valid_reg[$past(wr_idx)])
        else $error("registered range not marked valid");

    a_free_clears_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && do_free |=> !valid_reg[$past(wr_idx)])
        else $error("freed entry still valid");

    a_freed_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        freed_reg |-> (status_reg == ST_DONE))
        else $error("entry freed with a failing status");

endmodule
